FILE: rtl/core/spq_pkg.sv
// Shared types and constants for the sorted priority queue.
`timescale 1ns / 1ps
`default_nettype none
package spq_pkg;

    localparam int DEPTH         = 32;
    localparam int KEY_WIDTH     = 16;
    localparam int COUNT_W       = $clog2(DEPTH + 1);
    localparam int FIELD_W       = 16;
    localparam int OP_W          = 2;
    localparam int STATUS_W      = 2;
    localparam int COUNT_FIELD_W = 6;

    typedef logic signed [KEY_WIDTH-1:0] key_t;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_POP    = 2'd1,
        OP_DELETE = 2'd2,
        OP_CLEAR  = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    // Broadcast from the control logic to every cell of the chain.
    typedef struct packed {
        logic apply;
        op_t  op;
        key_t key;
    } cell_cmd_t;

    // What a cell shows to its neighbors and to the control logic.
    typedef struct packed {
        logic valid;
        key_t entry;
        logic lt;
        logic match;
    } cell_stat_t;

endpackage
`default_nettype wire

FILE: rtl/core/spq_if.sv
// Request and response channel interfaces of the sorted priority queue.
`timescale 1ns / 1ps
`default_nettype none
interface spq_req_if import spq_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [OP_W-1:0]           op;
    logic signed [FIELD_W-1:0] key;

    modport source (output valid, output op, output key, input ready);
    modport sink (input valid, input op, input key, output ready);
endinterface

interface spq_rsp_if import spq_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [FIELD_W-1:0] value;
    logic [STATUS_W-1:0]       status;
    logic [COUNT_FIELD_W-1:0]  count;

    modport source (output valid, output value, output status, output count, input ready);
    modport sink (input valid, input value, input status, input count, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/spq_cell.sv
// One storage cell of the sorted chain: holds one entry and its valid bit.
`timescale 1ns / 1ps
`default_nettype none
module spq_cell import spq_pkg::*; (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire cell_cmd_t  cmd,
    input  wire cell_stat_t prev,
    input  wire cell_stat_t next,
    output      cell_stat_t stat
);

    logic valid_reg;
    logic valid_next;
    key_t entry_reg;
    key_t entry_next;
    logic lt;

    assign lt = valid_reg && (entry_reg < cmd.key);

    assign stat.valid = valid_reg;
    assign stat.entry = entry_reg;
    assign stat.lt    = lt;
    assign stat.match = valid_reg && (entry_reg == cmd.key);

    always_comb
    begin
        valid_next = valid_reg;
        entry_next = entry_reg;
        if (cmd.apply)
        begin
            unique case (cmd.op)
                OP_INSERT:
                begin
                    // Cells above the insertion point move one place toward the tail.
                    if (!lt)
                    begin
                        entry_next = prev.lt ? cmd.key : prev.entry;
                    end
                    valid_next = valid_reg | prev.valid;
                end
                OP_POP:
                begin
                    entry_next = next.entry;
                    valid_next = next.valid;
                end
                OP_DELETE:
                begin
                    // The first match and everything after it close up by one place.
                    if (!lt)
                    begin
                        entry_next = next.entry;
                        valid_next = next.valid;
                    end
                end
                OP_CLEAR:
                begin
                    valid_next = 1'b0;
                end
                default:
                begin
                    valid_next = valid_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule
`default_nettype wire

FILE: rtl/core/sorted_priority_queue_core.sv
// Top level of the sorted priority queue: control logic and the chain of cells.
//
//   channel | dir | fields               | request moves
//   --------+-----+----------------------+------------------------------
//   req     | in  | op, key              | one queue operation
//   rsp     | out | value, status, count | the result of one operation
//
// All cells compare against the broadcast key at once and shift toward their
// neighbor at the clock edge, so a new request can be taken in every cycle.
// The result sits in an output register; a new request is taken while that
// register is empty or is being emptied. A stall on rsp holds req off. Reset
// empties the queue and drops any pending result.
`timescale 1ns / 1ps
`default_nettype none
module sorted_priority_queue_core import spq_pkg::*; (
    input  wire logic clk,
    input  wire logic rst_n,
    spq_req_if.sink   req,
    spq_rsp_if.source rsp
);

    cell_cmd_t  cmd;
    cell_stat_t stat [DEPTH];
    logic [DEPTH-1:0] match_vec;

    logic               accept;
    op_t                op;
    key_t               key;
    logic               full;
    logic               empty;
    logic               found;

    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic               rsp_valid_reg;
    logic               rsp_valid_next;
    logic signed [FIELD_W-1:0] rsp_value_reg;
    logic signed [FIELD_W-1:0] rsp_value_next;
    status_t            rsp_status_reg;
    status_t            rsp_status_next;
    logic [COUNT_FIELD_W-1:0]  rsp_count_reg;

    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;
    assign op        = op_t'(req.op);
    assign key       = KEY_WIDTH'(req.key);

    assign full  = (count_reg == COUNT_W'(DEPTH));
    assign empty = (count_reg == '0);
    assign found = |match_vec;

    always_comb
    begin
        cmd.op          = op;
        cmd.key         = key;
        cmd.apply       = 1'b0;
        count_next      = count_reg;
        rsp_value_next  = '0;
        rsp_status_next = ST_OK;
        unique case (op)
            OP_INSERT:
            begin
                if (full)
                begin
                    rsp_status_next = ST_FULL;
                end
                else
                begin
                    cmd.apply  = accept;
                    count_next = count_reg + 1'b1;
                end
            end
            OP_POP:
            begin
                if (empty)
                begin
                    rsp_status_next = ST_EMPTY;
                end
                else
                begin
                    cmd.apply      = accept;
                    count_next     = count_reg - 1'b1;
                    rsp_value_next = FIELD_W'(stat[0].entry);
                end
            end
            OP_DELETE:
            begin
                if (!found)
                begin
                    rsp_status_next = ST_NOT_FOUND;
                end
                else
                begin
                    // The removed entry equals the key, so the key is returned.
                    cmd.apply      = accept;
                    count_next     = count_reg - 1'b1;
                    rsp_value_next = FIELD_W'(key);
                end
            end
            OP_CLEAR:
            begin
                cmd.apply  = accept;
                count_next = '0;
            end
            default:
            begin
                cmd.apply = 1'b0;
            end
        endcase
    end

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            cell_stat_t prev_stat;
            cell_stat_t next_stat;

            assign match_vec[gi] = stat[gi].match;

            if (gi == 0)
            begin : g_head
                // The head sees a virtual smaller, valid neighbor in front of it.
                assign prev_stat.valid = 1'b1;
                assign prev_stat.entry = '0;
                assign prev_stat.lt    = 1'b1;
                assign prev_stat.match = 1'b0;
            end
            else
            begin : g_body
                assign prev_stat = stat[gi-1];
            end

            if (gi == DEPTH - 1)
            begin : g_tail
                assign next_stat.valid = 1'b0;
                assign next_stat.entry = '0;
                assign next_stat.lt    = 1'b0;
                assign next_stat.match = 1'b0;
            end
            else
            begin : g_inner
                assign next_stat = stat[gi+1];
            end

            spq_cell u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .cmd   (cmd),
                .prev  (prev_stat),
                .next  (next_stat),
                .stat  (stat[gi])
            );
        end
    endgenerate

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (accept)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg <= count_next;
            end
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rsp_value_reg  <= rsp_value_next;
            rsp_status_reg <= rsp_status_next;
            rsp_count_reg  <= COUNT_FIELD_W'(count_next);
        end
    end

    assign rsp.valid  = rsp_valid_reg;
    assign rsp.value  = rsp_value_reg;
    assign rsp.status = rsp_status_reg;
    assign rsp.count  = rsp_count_reg;

endmodule
`default_nettype wire

FILE: verif/spq_result_checker.sv
// Checker that predicts and compares every result of the sorted priority queue.
`timescale 1ns / 1ps
module spq_result_checker import spq_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    spq_req_if   req,
    spq_rsp_if   rsp,
    output int   mismatches,
    output int   outstanding
);

    localparam int REPORT_LIMIT = 10;

    typedef struct {
        key_t                     value;
        status_t                  status;
        logic [COUNT_FIELD_W-1:0] count;
    } outcome_t;

    // Stored values in ascending order, head first.
    key_t     held[$];
    outcome_t outcome_q[$];

    function automatic outcome_t predict_outcome(input op_t op, input key_t key);
        outcome_t res;
        int       pos;
        res.value  = '0;
        res.status = ST_OK;
        case (op)
            OP_INSERT:
            begin
                if (held.size() >= DEPTH)
                begin
                    res.status = ST_FULL;
                end
                else
                begin
                    // The new key goes in front of any equal values.
                    pos = 0;
                    while (pos < held.size() && held[pos] < key)
                        pos++;
                    held.insert(pos, key);
                end
            end
            OP_POP:
            begin
                if (held.size() == 0)
                    res.status = ST_EMPTY;
                else
                    res.value = held.pop_front();
            end
            OP_DELETE:
            begin
                res.status = ST_NOT_FOUND;
                for (pos = 0; pos < held.size(); pos++)
                begin
                    if (held[pos] == key)
                    begin
                        res.value  = held[pos];
                        res.status = ST_OK;
                        held.delete(pos);
                        break;
                    end
                end
            end
            default:
            begin
                held.delete();
            end
        endcase
        res.count = COUNT_FIELD_W'(held.size());
        return res;
    endfunction

    task automatic note_mismatch(input outcome_t want, input logic have_want);
        if (mismatches < REPORT_LIMIT)
        begin
            if (have_want)
                $display("%0t: result mismatch: expected value %0d status %0d count %0d, got value %0d status %0d count %0d",
                         $time, want.value, want.status, want.count,
                         rsp.value, rsp.status, rsp.count);
            else
                $display("%0t: result with no request pending: value %0d status %0d count %0d",
                         $time, rsp.value, rsp.status, rsp.count);
        end
        mismatches++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        outcome_t want;
        if (!rst_n)
        begin
            held.delete();
            outcome_q.delete();
        end
        else
        begin
            if (req.valid && req.ready)
                outcome_q.push_back(predict_outcome(op_t'(req.op), key_t'(req.key)));
            if (rsp.valid && rsp.ready)
            begin
                if (outcome_q.size() == 0)
                begin
                    note_mismatch(want, 1'b0);
                end
                else
                begin
                    want = outcome_q.pop_front();
                    if (rsp.value !== want.value || rsp.status !== want.status
                        || rsp.count !== want.count)
                        note_mismatch(want, 1'b1);
                end
            end
        end
        outstanding = outcome_q.size();
    end

endmodule

FILE: verif/tb.sv
// Testbench top: drives queue requests and response stalls and gives the verdict.
`timescale 1ns / 1ps
module tb;
    import spq_pkg::*;

    localparam int   TOTAL_ITEMS  = 1150;
    localparam int   CYCLE_LIMIT  = 400000;
    localparam int   DRAIN_CYCLES = 16;
    localparam int   RECENT_KEEP  = 16;
    localparam key_t KEY_MIN      = {1'b1, {(KEY_WIDTH-1){1'b0}}};
    localparam key_t KEY_MAX      = {1'b0, {(KEY_WIDTH-1){1'b1}}};

    logic clk;
    logic rst_n;
    int   send_idle_pct;
    int   recv_idle_pct;
    int   items_sent;
    int   mismatches;
    int   outstanding;
    int   cycle_count = 0;
    key_t inserted_keys[$];

    spq_req_if req();
    spq_rsp_if rsp();

    sorted_priority_queue_core dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    spq_result_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req),
        .rsp         (rsp),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("FAIL sorted_priority_queue_core");
            $finish;
        end
    end

    // Response side: stalls at random, one decision per cycle.
    initial
    begin
        rsp.ready <= 1'b0;
        forever
        begin
            @(negedge clk);
            rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    function automatic key_t random_key();
        case ($urandom_range(7))
            0:
            begin
                case ($urandom_range(3))
                    0: return KEY_MIN;
                    1: return KEY_MAX;
                    2: return '0;
                    default: return '1;
                endcase
            end
            1, 2: return key_t'(int'($urandom_range(15)) - 8);
            default: return key_t'($urandom);
        endcase
    endfunction

    // Deletes mostly aim at keys that were inserted lately, so that matches are common.
    function automatic key_t delete_key();
        if (inserted_keys.size() > 0 && $urandom_range(9) < 7)
            return inserted_keys[$urandom_range(inserted_keys.size() - 1)];
        return random_key();
    endfunction

    // Called at a falling edge; returns at the falling edge after the request is taken.
    task automatic push_request(input op_t op, input key_t key);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req.valid <= 1'b0;
            @(negedge clk);
        end
        req.valid <= 1'b1;
        req.op    <= op;
        req.key   <= key;
        do
            @(posedge clk);
        while (!req.ready);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic insert_key(input key_t key);
        inserted_keys.push_back(key);
        if (inserted_keys.size() > RECENT_KEEP)
            void'(inserted_keys.pop_front());
        push_request(OP_INSERT, key);
    endtask

    task automatic mixed_request();
        int pick;
        pick = $urandom_range(99);
        if (pick < 38)
            insert_key(random_key());
        else if (pick < 66)
            push_request(OP_POP, random_key());
        else if (pick < 96)
            push_request(OP_DELETE, delete_key());
        else
            push_request(OP_CLEAR, random_key());
    endtask

    initial
    begin
        items_sent    = 0;
        send_idle_pct = 28;
        recv_idle_pct = 83;
        rst_n     <= 1'b0;
        req.valid <= 1'b0;
        req.op    <= OP_INSERT;
        req.key   <= '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Operations on an empty queue, then extremes, duplicates and misses.
        push_request(OP_POP, KEY_MAX);
        push_request(OP_DELETE, key_t'(5));
        push_request(OP_CLEAR, '1);
        insert_key('0);
        insert_key(KEY_MAX);
        insert_key(KEY_MIN);
        insert_key('1);
        insert_key('0);
        insert_key(key_t'(1));
        push_request(OP_DELETE, '0);
        push_request(OP_DELETE, key_t'(12345));
        push_request(OP_POP, '0);
        push_request(OP_DELETE, KEY_MAX);
        insert_key(key_t'(16'h5555));
        insert_key(key_t'(16'hAAAA));
        push_request(OP_POP, KEY_MIN);
        push_request(OP_POP, '1);
        push_request(OP_CLEAR, KEY_MAX);
        push_request(OP_POP, '0);
        insert_key(KEY_MIN);
        push_request(OP_DELETE, KEY_MIN);
        push_request(OP_DELETE, KEY_MIN);

        while (items_sent < TOTAL_ITEMS)
        begin
            if (items_sent < TOTAL_ITEMS / 3)
            begin
                send_idle_pct = 28;
                recv_idle_pct = 83;
            end
            else if (items_sent < 2 * TOTAL_ITEMS / 3)
            begin
                send_idle_pct = 83;
                recv_idle_pct = 28;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            case ($urandom_range(9))
                0, 1:
                begin
                    // Fill past capacity, then try the smallest key at the head.
                    repeat (DEPTH + $urandom_range(1, 4)) insert_key(random_key());
                    repeat ($urandom_range(1, 2)) push_request(OP_INSERT, KEY_MIN);
                end
                2:
                begin
                    repeat (DEPTH / 2 + $urandom_range(DEPTH)) push_request(OP_POP, random_key());
                end
                3:
                begin
                    push_request(OP_CLEAR, random_key());
                end
                default:
                begin
                    repeat ($urandom_range(8, 24)) mixed_request();
                end
            endcase
        end
        req.valid <= 1'b0;

        while (outstanding != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("PASS sorted_priority_queue_core");
        else
            $display("FAIL sorted_priority_queue_core");
        $finish;
    end

endmodule

FILE: sorted_priority_queue_core.f
rtl/core/spq_pkg.sv
rtl/core/spq_if.sv
rtl/core/spq_cell.sv
rtl/core/sorted_priority_queue_core.sv
verif/spq_result_checker.sv
verif/tb.sv
